[hw/rtl/ogbu_pkg.sv]
// ----------------------------------------------------------------------------
// Occupancy grid beam update package
// Grid size, fixed-point widths, register codes and the controller states
// shared by the grid update block.
// ----------------------------------------------------------------------------
package ogbu_pkg;

   // grid geometry
   localparam int GRID_ROWS = 64;
   localparam int GRID_COLS = 64;
   localparam int NCELLS    = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W    = $clog2(NCELLS);
   localparam int ROW_W     = $clog2(GRID_ROWS);
   localparam int COL_W     = $clog2(GRID_COLS);

   // one grid entry: explored flag over a Q0.16 occupancy
   localparam int CELL_W = 17;

   // datapath widths
   localparam int V_W   = 30;  // cell centre minus laser, Q.9 signed
   localparam int LO_W  = 15;  // low slice of v for the split multiplies
   localparam int C_W   = 33;  // cone edge coefficients
   localparam int ACC_W = 64;  // multiply-accumulate
   localparam int D2_W  = 60;  // squared distance
   localparam int DN_W  = 52;  // divider dividend
   localparam int DD_W  = 36;  // divider divisor
   localparam int Q_W   = 17;  // divider quotient bits
   localparam int SQ_W  = 34;  // square root operand
   localparam int CNT_W = 5;

   localparam logic [15:0] PMAX_NEAR = 16'd64225;
   localparam logic [15:0] PMAX_FAR  = 16'd64881;
   localparam logic [15:0] OCC_INIT  = 16'd32768;
   localparam logic [12:0] COUNT_MAX = 13'd8191;

   typedef enum logic [2:0] {
      CSR_CELL_SIZE = 3'd0,
      CSR_X_MIN     = 3'd1,
      CSR_Y_MIN     = 3'd2,
      CSR_CONE_COS  = 3'd3,
      CSR_CONE_SIN  = 3'd4,
      CSR_NEAR_BAND = 3'd5,
      CSR_MAX_RANGE = 3'd6
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SETUP,
      ST_MAC,
      ST_CHECK,
      ST_SQRT,
      ST_PMUL,
      ST_PDIV,
      ST_BMUL,
      ST_BSUM,
      ST_BDIV,
      ST_BFIN,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/occupancy_grid_beam_update.sv]
// ----------------------------------------------------------------------------
// Occupancy grid beam update
// Bayesian occupancy grid with explored flags, updated one echo at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory once, one cell a cycle, and
// takes no item until that pass is done. A read item passes through the read
// and done states to the output register. An echo item visits every cell in
// turn through one grid memory read-modify-write: each cell runs its distance
// and cone tests on the shared 33 x 16 multiply-accumulate unit, and a cell
// inside the beam then runs the bit-serial square root and the two radix-2
// divisions of the Bayes update before its write-back.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module occupancy_grid_beam_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [23:0] req_laser_x,
   input  logic signed [23:0] req_laser_y,
   input  logic signed [15:0] req_beam_dx,
   input  logic signed [15:0] req_beam_dy,
   input  logic [15:0]        req_hit_distance,
   input  logic [5:0]         req_cell_row,
   input  logic [5:0]         req_cell_col,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_occupancy,
   output logic               rsp_explored,
   output logic [12:0]        rsp_near_count,
   output logic [12:0]        rsp_far_count,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import ogbu_pkg::*;

   localparam logic [3:0] T_D2_END = 4'd3;
   localparam logic [3:0] T_EA_END = 4'd7;
   localparam logic [3:0] T_EB_END = 4'd11;
   localparam logic [CNT_W-1:0] SQ_STEPS  = CNT_W'(SQ_W / 2);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(Q_W);

   // configuration
   logic [15:0]        cfg_cell_size_ff, cfg_near_band_ff, cfg_max_range_ff;
   logic signed [15:0] cfg_x_min_ff, cfg_y_min_ff;
   logic [14:0]        cfg_cone_cos_ff, cfg_cone_sin_ff;

   // item
   logic signed [23:0] lx_ff, ly_ff;
   logic signed [15:0] bx_ff, by_ff;
   logic [15:0]        hit_ff;
   logic               rd_oob_ff;

   // echo constants
   logic signed [C_W-1:0] ax_ff, ay_ff, qx_ff, qy_ff;
   logic [SQ_W-1:0]       rng2_ff, hit2_ff, nb2_ff;
   logic                  all_near_ff;
   logic [17:0]           twor_ff;
   logic signed [V_W-1:0] vx_base_ff, vx_ff, vy_ff;

   // walk
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cell_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [12:0]       near_cnt_ff, far_cnt_ff;

   // multiply-accumulate
   logic [3:0]              mstep_ff, pterm_ff;
   logic                    pvld_ff;
   logic signed [C_W+15:0]  prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [D2_W-1:0]         d2_ff;
   logic                    ea_pos_ff, eb_pos_ff;

   // per-cell update
   logic              near_ff, occ_upd_ff;
   logic [15:0]       p_old_ff, new_occ_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SQ_W-1:0]   sq_val_ff;
   logic [19:0]       sq_rem_ff;
   logic [16:0]       sq_res_ff;
   logic [DD_W:0]     div_rem_ff;
   logic [DN_W-1:0]   div_num_ff;
   logic [DD_W-1:0]   div_den_ff;
   logic [Q_W-1:0]    div_q_ff;
   logic [32:0]       mul_a_ff;
   logic [33:0]       mul_b_ff;

   // result
   logic        rsp_valid_ff, res_exp_ff, rsp_explored_ff;
   logic [15:0] res_occ_ff, rsp_occupancy_ff;
   logic [12:0] rsp_near_ff, rsp_far_ff;

   // memory
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_raddr, req_addr;
   logic [CELL_W-1:0]   ram_wdata, ram_rdata;

   // combinational helpers
   logic                   out_free, last_cell, handled, advance, div_load, den_zero;
   logic signed [15:0]     co, si, mac_b, vx_lo, vx_hi, vy_lo, vy_hi;
   logic signed [31:0]     bx_co, by_si, by_co, bx_si;
   logic signed [V_W-1:0]  vx_start, vy_start, step2;
   logic signed [C_W-1:0]  mac_a;
   logic signed [C_W+15:0] mac_p;
   logic signed [ACC_W-1:0] term_ext, term, acc_sum;
   logic [16:0]            r9, h9, nb9, p17, np17, wa, wb, np_old;
   logic [21:0]            sq_rem2, sq_trial;
   logic [17:0]            d9c;
   logic [15:0]            pm;
   logic [DN_W-1:0]        div_n;
   logic [DD_W-1:0]        div_d;
   logic [DD_W+1:0]        div_r2;
   logic                   div_ge;
   logic [34:0]            den;

   ogbu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NCELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // address of a read item
   assign req_addr = ADDR_W'(ADDR_W'(req_cell_row) * ADDR_W'(GRID_COLS))
                     + ADDR_W'(req_cell_col);
   assign ram_raddr = (state_ff == ST_IDLE) ? req_addr : cell_ff;

   // echo set-up terms
   assign co       = signed'({1'b0, cfg_cone_cos_ff});
   assign si       = signed'({1'b0, cfg_cone_sin_ff});
   assign bx_co    = bx_ff * co;
   assign by_si    = by_ff * si;
   assign by_co    = by_ff * co;
   assign bx_si    = bx_ff * si;
   assign step2    = V_W'({cfg_cell_size_ff, 1'b0});
   assign vx_start = (V_W'(cfg_x_min_ff) <<< 9) + V_W'(cfg_cell_size_ff)
                     - (V_W'(lx_ff) <<< 1);
   assign vy_start = (V_W'(cfg_y_min_ff) <<< 9) + V_W'(cfg_cell_size_ff)
                     - (V_W'(ly_ff) <<< 1);
   assign r9       = {cfg_max_range_ff, 1'b0};
   assign h9       = {hit_ff, 1'b0};
   assign nb9      = (cfg_near_band_ff >= hit_ff) ? 17'd0
                     : {hit_ff - cfg_near_band_ff, 1'b0};

   // operand select for the shared multiplier
   assign vx_lo = signed'({1'b0, vx_ff[LO_W-1:0]});
   assign vx_hi = 16'(signed'(vx_ff[V_W-1:LO_W]));
   assign vy_lo = signed'({1'b0, vy_ff[LO_W-1:0]});
   assign vy_hi = 16'(signed'(vy_ff[V_W-1:LO_W]));

   always_comb begin
      mac_a = '0;
      mac_b = '0;
      case (mstep_ff)
         4'd0:    begin mac_a = C_W'(vx_ff); mac_b = vx_lo; end
         4'd1:    begin mac_a = C_W'(vx_ff); mac_b = vx_hi; end
         4'd2:    begin mac_a = C_W'(vy_ff); mac_b = vy_lo; end
         4'd3:    begin mac_a = C_W'(vy_ff); mac_b = vy_hi; end
         4'd4:    begin mac_a = ay_ff; mac_b = vx_lo; end
         4'd5:    begin mac_a = ay_ff; mac_b = vx_hi; end
         4'd6:    begin mac_a = ax_ff; mac_b = vy_lo; end
         4'd7:    begin mac_a = ax_ff; mac_b = vy_hi; end
         4'd8:    begin mac_a = qx_ff; mac_b = vy_lo; end
         4'd9:    begin mac_a = qx_ff; mac_b = vy_hi; end
         4'd10:   begin mac_a = qy_ff; mac_b = vx_lo; end
         4'd11:   begin mac_a = qy_ff; mac_b = vx_hi; end
         default: begin mac_a = '0; mac_b = '0; end
      endcase
   end
   assign mac_p = mac_a * mac_b;

   // align and sign the registered partial product; odd terms are high slices
   assign term_ext = ACC_W'(prod_ff);
   always_comb begin
      term = pterm_ff[0] ? (term_ext <<< LO_W) : term_ext;
      if (pterm_ff[1] && (pterm_ff[3:2] != 2'b00)) begin
         term = -term;
      end
   end
   assign acc_sum = acc_ff + term;

   // cell tests
   assign handled = (d2_ff < D2_W'(rng2_ff)) && (d2_ff <= D2_W'(hit2_ff))
                    && !ea_pos_ff && !eb_pos_ff;
   assign last_cell = (cell_ff == ADDR_W'(NCELLS - 1));

   // square root step
   assign sq_rem2  = {sq_rem_ff, sq_val_ff[SQ_W-1:SQ_W-2]};
   assign sq_trial = {3'b000, sq_res_ff, 2'b01};

   // sensor model and Bayes weights
   assign d9c    = (18'(sq_res_ff) > twor_ff) ? twor_ff : 18'(sq_res_ff);
   assign pm     = near_ff ? PMAX_NEAR : PMAX_FAR;
   assign p17    = div_q_ff;
   assign np17   = 17'h10000 - p17;
   assign wa     = near_ff ? p17 : np17;
   assign wb     = near_ff ? np17 : p17;
   assign np_old = 17'h10000 - 17'(p_old_ff);
   assign den    = 35'(mul_a_ff) + 35'(mul_b_ff);
   assign den_zero = (den == '0);

   // divider load and step
   always_comb begin
      div_n = DN_W'({mul_a_ff, 16'h0000});
      div_d = DD_W'(den);
      if (state_ff == ST_PMUL) begin
         div_n = DN_W'(34'(pm) * 34'(twor_ff - d9c));
         div_d = DD_W'(twor_ff);
      end
   end
   assign div_load = (state_ff == ST_PMUL) || ((state_ff == ST_BSUM) && !den_zero);
   assign div_r2   = {div_rem_ff, div_num_ff[DN_W-1]};
   assign div_ge   = (div_r2 >= (DD_W+2)'(div_den_ff));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_wdata = {1'b1, new_occ_ff};
      advance   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, OCC_INIT};
            if (last_cell) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_command ? ST_READ : ST_SETUP;
            end
         end
         ST_READ:  state_in = ST_DONE;
         ST_SETUP: state_in = ST_MAC;
         ST_MAC: begin
            if (pvld_ff && (pterm_ff == T_EB_END)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!handled) begin
               advance  = 1'b1;
               state_in = last_cell ? ST_DONE : ST_MAC;
            end else if (twor_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: state_in = ST_PDIV;
         ST_PDIV: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_BMUL;
            end
         end
         ST_BMUL: state_in = ST_BSUM;
         ST_BSUM: state_in = den_zero ? ST_WRITE : ST_BDIV;
         ST_BDIV: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_BFIN;
            end
         end
         ST_BFIN: state_in = ST_WRITE;
         ST_WRITE: begin
            ram_we   = 1'b1;
            advance  = 1'b1;
            state_in = last_cell ? ST_DONE : ST_MAC;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cell_size_ff <= 16'd256;
         cfg_x_min_ff     <= 16'sd0;
         cfg_y_min_ff     <= 16'sd0;
         cfg_cone_cos_ff  <= 15'd31651;
         cfg_cone_sin_ff  <= 15'd8481;
         cfg_near_band_ff <= 16'd256;
         cfg_max_range_ff <= 16'd10240;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            CSR_CELL_SIZE: cfg_cell_size_ff <= csr_data;
            CSR_X_MIN:     cfg_x_min_ff     <= signed'(csr_data);
            CSR_Y_MIN:     cfg_y_min_ff     <= signed'(csr_data);
            CSR_CONE_COS:  cfg_cone_cos_ff  <= csr_data[14:0];
            CSR_CONE_SIN:  cfg_cone_sin_ff  <= csr_data[14:0];
            CSR_NEAR_BAND: cfg_near_band_ff <= csr_data;
            CSR_MAX_RANGE: cfg_max_range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // control counters and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         mstep_ff     <= '0;
         pvld_ff      <= 1'b0;
         cnt_ff       <= '0;
         near_cnt_ff  <= '0;
         far_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pvld_ff <= (state_ff == ST_MAC) && (mstep_ff <= T_EB_END);
         if (state_ff == ST_MAC) begin
            mstep_ff <= mstep_ff + 4'd1;
         end

         // sweep the grid after reset
         if (state_ff == ST_CLEAR) begin
            cell_ff <= last_cell ? '0 : cell_ff + ADDR_W'(1);
         end

         // start of an item
         if (state_ff == ST_IDLE && req_valid) begin
            near_cnt_ff <= '0;
            far_cnt_ff  <= '0;
         end
         if (state_ff == ST_SETUP) begin
            cell_ff  <= '0;
            row_ff   <= '0;
            col_ff   <= '0;
            mstep_ff <= '0;
         end

         // count updated cells, saturating
         if (state_ff == ST_WRITE && occ_upd_ff) begin
            if (near_ff && near_cnt_ff != COUNT_MAX) begin
               near_cnt_ff <= near_cnt_ff + 13'd1;
            end
            if (!near_ff && far_cnt_ff != COUNT_MAX) begin
               far_cnt_ff <= far_cnt_ff + 13'd1;
            end
         end

         // advance to the next cell
         if (advance && !last_cell) begin
            cell_ff  <= cell_ff + ADDR_W'(1);
            mstep_ff <= '0;
            if (col_ff == COL_W'(GRID_COLS - 1)) begin
               col_ff <= '0;
               row_ff <= row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end

         // iteration counter of the root and divider
         if (state_ff == ST_CHECK || div_load) begin
            cnt_ff <= (state_ff == ST_CHECK) ? SQ_STEPS : DIV_STEPS;
         end else if (state_ff == ST_SQRT || state_ff == ST_PDIV
                      || state_ff == ST_BDIV) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end

         // output register
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      // capture the item
      if (state_ff == ST_IDLE && req_valid) begin
         lx_ff      <= req_laser_x;
         ly_ff      <= req_laser_y;
         bx_ff      <= req_beam_dx;
         by_ff      <= req_beam_dy;
         hit_ff     <= req_hit_distance;
         rd_oob_ff  <= (32'(req_cell_row) >= GRID_ROWS) || (32'(req_cell_col) >= GRID_COLS);
         res_occ_ff <= '0;
         res_exp_ff <= 1'b0;
      end

      if (state_ff == ST_READ && !rd_oob_ff) begin
         res_occ_ff <= ram_rdata[15:0];
         res_exp_ff <= ram_rdata[CELL_W-1];
      end

      // per-echo constants
      if (state_ff == ST_SETUP) begin
         ax_ff       <= C_W'(bx_co) + C_W'(by_si);
         ay_ff       <= C_W'(by_co) - C_W'(bx_si);
         qx_ff       <= C_W'(bx_co) - C_W'(by_si);
         qy_ff       <= C_W'(bx_si) + C_W'(by_co);
         rng2_ff     <= r9 * r9;
         hit2_ff     <= h9 * h9;
         nb2_ff      <= nb9 * nb9;
         all_near_ff <= cfg_near_band_ff >= hit_ff;
         twor_ff     <= {cfg_max_range_ff, 2'b00};
         vx_base_ff  <= vx_start;
         vx_ff       <= vx_start;
         vy_ff       <= vy_start;
         acc_ff      <= '0;
      end

      // step the cell centre offsets
      if (advance && !last_cell) begin
         if (col_ff == COL_W'(GRID_COLS - 1)) begin
            vx_ff <= vx_base_ff;
            vy_ff <= vy_ff + step2;
         end else begin
            vx_ff <= vx_ff + step2;
         end
      end

      // accumulate partial products; close a sum every fourth term
      prod_ff  <= mac_p;
      pterm_ff <= mstep_ff;
      if (pvld_ff) begin
         if (pterm_ff[1:0] == 2'b11) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_sum;
         end
         if (pterm_ff == T_D2_END) begin
            d2_ff <= D2_W'(acc_sum);
         end
         if (pterm_ff == T_EA_END) begin
            ea_pos_ff <= acc_sum > 0;
         end
         if (pterm_ff == T_EB_END) begin
            eb_pos_ff <= acc_sum > 0;
         end
      end

      // classify the cell and start the root
      if (state_ff == ST_CHECK) begin
         p_old_ff   <= ram_rdata[15:0];
         new_occ_ff <= ram_rdata[15:0];
         near_ff    <= all_near_ff || (d2_ff > D2_W'(nb2_ff));
         occ_upd_ff <= twor_ff != '0;
         sq_val_ff  <= d2_ff[SQ_W-1:0];
         sq_rem_ff  <= '0;
         sq_res_ff  <= '0;
      end

      // one root bit a cycle
      if (state_ff == ST_SQRT) begin
         sq_val_ff <= sq_val_ff << 2;
         if (sq_rem2 >= sq_trial) begin
            sq_rem_ff <= 20'(sq_rem2 - sq_trial);
            sq_res_ff <= {sq_res_ff[15:0], 1'b1};
         end else begin
            sq_rem_ff <= 20'(sq_rem2);
            sq_res_ff <= {sq_res_ff[15:0], 1'b0};
         end
      end

      // one quotient bit a cycle
      if (div_load) begin
         div_rem_ff <= (DD_W+1)'(div_n >> Q_W);
         div_num_ff <= div_n << (DN_W - Q_W);
         div_den_ff <= div_d;
         div_q_ff   <= '0;
      end else if (state_ff == ST_PDIV || state_ff == ST_BDIV) begin
         div_num_ff <= div_num_ff << 1;
         div_q_ff   <= {div_q_ff[Q_W-2:0], div_ge};
         if (div_ge) begin
            div_rem_ff <= (DD_W+1)'(div_r2 - (DD_W+2)'(div_den_ff));
         end else begin
            div_rem_ff <= (DD_W+1)'(div_r2);
         end
      end

      // Bayes numerator and complement terms
      if (state_ff == ST_BMUL) begin
         mul_a_ff <= 33'(wa) * 33'(p_old_ff);
         mul_b_ff <= 34'(wb) * 34'(np_old);
      end

      // clamp the ratio to the top code
      if (state_ff == ST_BFIN) begin
         new_occ_ff <= div_q_ff[Q_W-1] ? 16'hFFFF : div_q_ff[15:0];
      end

      // load the result
      if (state_ff == ST_DONE && out_free) begin
         rsp_occupancy_ff <= res_occ_ff;
         rsp_explored_ff  <= res_exp_ff;
         rsp_near_ff      <= near_cnt_ff;
         rsp_far_ff       <= far_cnt_ff;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_explored   = rsp_explored_ff;
   assign rsp_near_count = rsp_near_ff;
   assign rsp_far_count  = rsp_far_ff;

   // grid memory is written only by the clearing pass or a cell write-back
   a_ram_we_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_WRITE))
      else $error("grid write outside clear or write-back");

   // no result while the grid is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   // a result appears only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside done state");

   // iterative units never run with an exhausted counter
   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT || state_ff == ST_PDIV || state_ff == ST_BDIV)
      |-> (cnt_ff != '0))
      else $error("iteration counter underflow");

endmodule

[hw/rtl/ogbu_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ogbu_ram #(
   parameter int WIDTH  = 17,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
